[src/tsi_pkg.sv]
// Shared types, widths and codes of the tabulated sample integrator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tsi_pkg;

    // Longest run that is held; further samples of a run are dropped.
    localparam int MAX_SAMPLES = 65536;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int XY_W   = 32;  // Q16.16 sample fields
    localparam int DX_W   = 33;  // difference or sum of two samples
    localparam int MODE_W = 2;
    localparam int RES_W  = 48;  // Q32.16 result
    localparam int STAT_W = 2;
    localparam int SUM_W  = 52;  // parity sums of interior ordinates
    localparam int AREA_W = 64;  // saturating sum of uneven terms
    localparam int S_W    = 56;  // weighted ordinate sum of the closing step
    localparam int SMAG_W = S_W - 1;
    localparam int MA_W   = 32;  // multiplier operand A (step magnitude)
    localparam int MB_W   = 33;  // multiplier operand B
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 88;  // full product of step and weighted sum
    localparam int DQ_W   = 72;  // dividend after the 2^16 scaling
    localparam int HI_W   = SMAG_W - MB_W;

    // Divide by 3 a chunk at a time: remainder and chunk times a reciprocal.
    localparam int CHUNK_W  = 24;
    localparam int N_CHUNK  = DQ_W / CHUNK_W;
    localparam int BIT_W    = $clog2(N_CHUNK);
    localparam int RECIP_SH = CHUNK_W + 3;
    localparam int DPROD_W  = 2 * (CHUNK_W + 2);
    localparam logic [CHUNK_W+1:0] DIV3_RECIP = (CHUNK_W + 2)'((2 ** RECIP_SH + 1) / 3);

    // Queue between front and back: power of two so the pointers wrap.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Integration modes; the unused code behaves as Simpson.
    localparam logic [MODE_W-1:0] MODE_EQ_TRAP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNEVEN_TRAP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIMPSON     = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_EVEN_COUNT = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_FEW    = 2'd2;

    // Rounding offsets: half the divisor (2^17 or 3 * 2^16).
    localparam logic [ACC_W-1:0]  HALF_TRAP = ACC_W'(65536);
    localparam logic [ACC_W-1:0]  HALF_SIMP = ACC_W'(98304);
    localparam logic [PROD_W:0]   TERM_HALF = (PROD_W + 1)'(65536);
    localparam logic [1:0]        DIV_TRAP  = 2'd2;
    localparam logic [1:0]        DIV_SIMP  = 2'd3;

    // What the back has to do with a queued sample.
    typedef enum logic [2:0] {
        K_FIRST  = 3'd0,  // opens a run
        K_SECOND = 3'd1,  // sets the step width
        K_ODD    = 3'd2,  // previous ordinate has an odd index
        K_EVEN   = 3'd3,  // previous ordinate has an even index
        K_DROP   = 3'd4   // run already full, only its last flag counts
    } t_kind;

    // Sample count of the run as held after this sample.
    typedef struct packed {
        logic ge2;
        logic ge3;
        logic n_odd;
    } t_run_info;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic                   last;
        t_kind                  kind;
        t_run_info              info;
    } t_entry;

endpackage

[src/tsi_front.sv]
// Front of the integrator: accepts samples, counts the run and tags each one.
// Depends on tsi_pkg; feeds tsi_queue.
`timescale 1ns / 1ps

module tsi_front import tsi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [XY_W-1:0] i_x_value,
    input  logic signed [XY_W-1:0] i_y_value,
    input  logic                   i_last_sample,
    input  logic                   i_q_full,
    output logic                   o_ready,
    output logic                   o_push,
    output t_entry                 o_entry
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] held;
    logic             keep;
    logic             accept;

    assign keep   = r_count < CNT_W'(MAX_SAMPLES);
    assign held   = keep ? r_count + CNT_W'(1) : r_count;
    assign accept = i_valid && !i_q_full;

    assign o_ready = !i_q_full;
    // Drop a sample of a full run unless it closes the run.
    assign o_push  = accept && (keep || i_last_sample);

    always_comb begin
        o_entry.x          = i_x_value;
        o_entry.y          = i_y_value;
        o_entry.last       = i_last_sample;
        o_entry.info.ge2   = held >= CNT_W'(2);
        o_entry.info.ge3   = held >= CNT_W'(3);
        o_entry.info.n_odd = held[0];
        if (!keep) begin
            o_entry.kind = K_DROP;
        end else if (r_count == '0) begin
            o_entry.kind = K_FIRST;
        end else if (r_count == CNT_W'(1)) begin
            o_entry.kind = K_SECOND;
        end else if (r_count[0]) begin
            o_entry.kind = K_EVEN;
        end else begin
            o_entry.kind = K_ODD;
        end
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_last_sample) begin
                n_count = '0;
            end else if (keep) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_sample |=> r_count == '0)
        else $error("front count not cleared after the closing sample");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("front count beyond the run limit");
`endif

endmodule

[src/tsi_queue.sv]
// Short first-in first-out queue of tagged samples between front and back.
// Depends on tsi_pkg for the entry type and depth.
`timescale 1ns / 1ps

module tsi_queue import tsi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/tsi_back.sv]
// Back of the integrator: run sums, closing multiply, divide and saturation.
// Depends on tsi_pkg; takes tagged samples from tsi_queue.
`timescale 1ns / 1ps

module tsi_back import tsi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic                     i_q_valid,
    input  t_entry                   i_entry,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [RES_W-1:0]  o_integral,
    output logic [STAT_W-1:0]        o_status
);

    typedef enum logic [11:0] {
        S_IDLE = 12'h001,
        S_MUL  = 12'h002,
        S_ACC  = 12'h004,
        S_FIN  = 12'h008,
        S_FMG  = 12'h010,
        S_FML  = 12'h020,
        S_FMH  = 12'h040,
        S_FAD  = 12'h080,
        S_RND  = 12'h100,
        S_DIV  = 12'h200,
        S_SAT  = 12'h400,
        S_OUT  = 12'h800
    } t_state;

    t_state r_state, n_state;

    // run state
    logic signed [XY_W-1:0]   r_first_y;
    logic signed [XY_W-1:0]   r_prev_x;
    logic signed [XY_W-1:0]   r_prev_y;
    logic signed [DX_W-1:0]   r_step;
    logic signed [SUM_W-1:0]  r_odd;
    logic signed [SUM_W-1:0]  r_even;
    logic signed [AREA_W-1:0] r_area;
    logic                     r_last;
    t_run_info                r_info;

    // arithmetic datapath
    logic [MA_W-1:0]          r_ma;
    logic [MB_W-1:0]          r_mb;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    logic signed [S_W-1:0]    r_sum;
    logic [SMAG_W-1:0]        r_smag;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         r_half;
    logic [1:0]               r_div;
    logic [DQ_W-1:0]          r_dq;
    logic [1:0]               r_rem;
    logic [BIT_W-1:0]         r_bit;
    logic signed [RES_W-1:0]  r_res;
    logic [STAT_W-1:0]        r_stat;

    // output register
    logic                     r_out_valid;
    logic signed [RES_W-1:0]  r_out_integral;
    logic [STAT_W-1:0]        r_out_status;

    logic signed [DX_W-1:0]   dx;
    logic signed [DX_W-1:0]   ys;
    logic [DX_W-1:0]          dx_mag;
    logic [DX_W-1:0]          ys_mag;
    logic [PROD_W-1:0]        mul_out;
    logic [PROD_W:0]          term_round;
    logic [RES_W-1:0]         term_mag;
    logic signed [AREA_W:0]   term_s;
    logic signed [AREA_W:0]   area_sum;
    logic signed [AREA_W-1:0] area_next;
    logic signed [S_W-1:0]    fy_x, py_x, odd_x, even_x, simp_s, trap_s;
    logic                     is_simp;
    logic                     is_err;
    logic [STAT_W-1:0]        fin_stat;
    logic signed [RES_W-1:0]  area_res;
    logic [DX_W-1:0]          step_mag;
    logic [S_W-1:0]           sum_mag;
    logic [ACC_W-1:0]         rnd_sum;
    logic [CHUNK_W+1:0]       div_t;
    logic [DPROD_W-1:0]       div_prod;
    logic [CHUNK_W-1:0]       div_q;
    logic [CHUNK_W+1:0]       div_back;
    logic [CHUNK_W+1:0]       div_left;
    logic signed [RES_W-1:0]  sat_res;
    logic                     out_free;
    logic                     bit_done;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign bit_done = r_bit == BIT_W'(N_CHUNK - 1);

    // interval of the uneven trapezoid
    assign dx     = DX_W'(i_entry.x) - DX_W'(r_prev_x);
    assign ys     = DX_W'(i_entry.y) + DX_W'(r_prev_y);
    assign dx_mag = dx[DX_W-1] ? -dx : dx;
    assign ys_mag = ys[DX_W-1] ? -ys : ys;

    assign mul_out = PROD_W'(r_ma) * PROD_W'(r_mb);

    // round the interval term to nearest, ties away from zero, and add it
    assign term_round = {1'b0, r_prod} + TERM_HALF;
    assign term_mag   = term_round[PROD_W-1:17];
    assign term_s     = r_neg ? -(AREA_W + 1)'(term_mag) : (AREA_W + 1)'(term_mag);
    assign area_sum   = {r_area[AREA_W-1], r_area} + term_s;

    always_comb begin
        if (area_sum[AREA_W] != area_sum[AREA_W-1]) begin
            area_next = area_sum[AREA_W] ? {1'b1, {(AREA_W - 1){1'b0}}}
                                         : {1'b0, {(AREA_W - 1){1'b1}}};
        end else begin
            area_next = area_sum[AREA_W-1:0];
        end
    end

    // closing sums
    assign is_simp = i_mode[1];
    assign fy_x    = S_W'(r_first_y);
    assign py_x    = S_W'(r_prev_y);
    assign odd_x   = S_W'(r_odd);
    assign even_x  = S_W'(r_even);
    assign simp_s  = fy_x + py_x + (odd_x <<< 2) + (even_x <<< 1);
    assign trap_s  = fy_x + py_x + ((odd_x + even_x) <<< 1);

    always_comb begin
        fin_stat = ST_OK;
        if (is_simp) begin
            if (!r_info.ge3) begin
                fin_stat = ST_TOO_FEW;
            end else if (!r_info.n_odd) begin
                fin_stat = ST_EVEN_COUNT;
            end
        end else if (!r_info.ge2) begin
            fin_stat = ST_TOO_FEW;
        end
    end
    assign is_err = fin_stat != ST_OK;

    always_comb begin
        if (r_area > AREA_W'(signed'({1'b0, {(RES_W - 1){1'b1}}}))) begin
            area_res = {1'b0, {(RES_W - 1){1'b1}}};
        end else if (r_area < -AREA_W'(signed'({1'b0, 1'b1, {(RES_W - 1){1'b0}}}))) begin
            area_res = {1'b1, {(RES_W - 1){1'b0}}};
        end else begin
            area_res = r_area[RES_W-1:0];
        end
    end

    assign step_mag = r_step[DX_W-1] ? -r_step : r_step;
    assign sum_mag  = r_sum[S_W-1] ? -r_sum : r_sum;
    assign rnd_sum  = r_acc + r_half;

    // divide by 3 one chunk per cycle: reciprocal multiply, then the remainder
    assign div_t    = {r_rem, r_dq[DQ_W-1 -: CHUNK_W]};
    assign div_prod = DPROD_W'(div_t) * DPROD_W'(DIV3_RECIP);
    assign div_q    = div_prod[RECIP_SH +: CHUNK_W];
    assign div_back = (CHUNK_W + 2)'({div_q, 1'b0}) + (CHUNK_W + 2)'(div_q);
    assign div_left = div_t - div_back;

    always_comb begin
        if (r_neg) begin
            if (r_dq > DQ_W'({1'b1, {(RES_W - 1){1'b0}}})) begin
                sat_res = {1'b1, {(RES_W - 1){1'b0}}};
            end else begin
                sat_res = -signed'(r_dq[RES_W-1:0]);
            end
        end else if (r_dq > DQ_W'({(RES_W - 1){1'b1}})) begin
            sat_res = {1'b0, {(RES_W - 1){1'b1}}};
        end else begin
            sat_res = r_dq[RES_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_entry.kind == K_DROP) begin
                        n_state = S_FIN;
                    end else if (i_entry.kind == K_FIRST) begin
                        n_state = i_entry.last ? S_FIN : S_IDLE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = r_last ? S_FIN : S_IDLE;
            S_FIN: begin
                if (is_err || i_mode == MODE_UNEVEN_TRAP) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_FMG;
                end
            end
            S_FMG:   n_state = S_FML;
            S_FML:   n_state = S_FMH;
            S_FMH:   n_state = S_FAD;
            S_FAD:   n_state = S_RND;
            S_RND:   n_state = (r_div == DIV_SIMP) ? S_DIV : S_SAT;
            S_DIV:   n_state = bit_done ? S_SAT : S_DIV;
            S_SAT:   n_state = S_OUT;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_odd       <= '0;
            r_even      <= '0;
            r_area      <= '0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_last <= i_entry.last;
                        r_info <= i_entry.info;
                        if (i_entry.kind != K_DROP) begin
                            r_prev_x <= i_entry.x;
                            r_prev_y <= i_entry.y;
                        end
                        if (i_entry.kind == K_FIRST) begin
                            r_first_y <= i_entry.y;
                        end
                        if (i_entry.kind == K_SECOND) begin
                            r_step <= dx;
                        end
                        if (i_entry.kind == K_ODD) begin
                            r_odd <= r_odd + SUM_W'(r_prev_y);
                        end
                        if (i_entry.kind == K_EVEN) begin
                            r_even <= r_even + SUM_W'(r_prev_y);
                        end
                        r_ma  <= dx_mag[MA_W-1:0];
                        r_mb  <= ys_mag;
                        r_neg <= dx[DX_W-1] ^ ys[DX_W-1];
                    end
                end
                S_MUL: begin
                    r_prod <= mul_out;
                end
                S_ACC: begin
                    r_area <= area_next;
                end
                S_FIN: begin
                    r_stat <= fin_stat;
                    r_res  <= is_err ? '0 : area_res;
                    r_sum  <= is_simp ? simp_s : trap_s;
                    r_half <= is_simp ? HALF_SIMP : HALF_TRAP;
                    r_div  <= is_simp ? DIV_SIMP : DIV_TRAP;
                end
                S_FMG: begin
                    r_ma   <= step_mag[MA_W-1:0];
                    r_smag <= sum_mag[SMAG_W-1:0];
                    r_mb   <= sum_mag[MB_W-1:0];
                    r_neg  <= r_step[DX_W-1] ^ r_sum[S_W-1];
                end
                S_FML: begin
                    r_prod <= mul_out;
                    r_mb   <= MB_W'(r_smag[SMAG_W-1:MB_W]);
                end
                S_FMH: begin
                    r_acc  <= ACC_W'(r_prod);
                    r_prod <= mul_out;
                end
                S_FAD: begin
                    r_acc <= r_acc + (ACC_W'(r_prod) << MB_W);
                end
                S_RND: begin
                    // trapezoid: drop 17 bits; Simpson: drop 16, then divide by 3
                    if (r_div == DIV_SIMP) begin
                        r_dq <= rnd_sum[ACC_W-1:16];
                    end else begin
                        r_dq <= DQ_W'(rnd_sum[ACC_W-1:17]);
                    end
                    r_rem <= '0;
                    r_bit <= '0;
                end
                S_DIV: begin
                    r_rem <= div_left[1:0];
                    r_dq  <= {r_dq[DQ_W-CHUNK_W-1:0], div_q};
                    r_bit <= r_bit + BIT_W'(1);
                end
                S_SAT: begin
                    r_res <= sat_res;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_integral <= r_res;
                        r_out_status   <= r_stat;
                        // clear the run for the next table
                        r_odd  <= '0;
                        r_even <= '0;
                        r_area <= '0;
                        r_step <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_integral = r_out_integral;
    assign o_status   = r_out_status;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_integral == '0)
        else $error("error result with a nonzero integral");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && bit_done |=> r_state == S_SAT)
        else $error("divider did not finish after its last chunk");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !out_free |=> r_state == S_OUT)
        else $error("result left before the output register was free");
`endif

endmodule

[src/tabulated_sample_integrator.sv]
// Top level of the tabulated sample integrator: mode register and the
// front, queue and back parts. Depends on tsi_pkg, tsi_front, tsi_queue, tsi_back.
//
//  channel   direction  handshake             payload
//  sample    in         i_valid / o_ready     i_x_value, i_y_value, i_last_sample
//  result    out        o_valid / i_ready     o_integral, o_status
//  config    in         i_cfg_we              i_cfg_data (integration mode)
//
// The front takes one sample per cycle into a two-entry queue while it has room.
// The back only registers the opening sample of a run and takes every
// other sample in turn (difference, 32 x 33 multiply, rounded saturating add),
// popping no new sample before the last one is done. A closing sample adds a
// status for the uneven trapezoid or an error; other modes add a weighted sum, two
// multiply passes, rounding, and for Simpson a divide by 3 in three 24-bit steps.
// Reset is synchronous and active low; it clears the run and sets mode 0.
// A stalled result holds in the output register while the front keeps filling.
`timescale 1ns / 1ps

module tabulated_sample_integrator import tsi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [XY_W-1:0]   i_x_value,
    input  logic signed [XY_W-1:0]   i_y_value,
    input  logic                     i_last_sample,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [RES_W-1:0]  o_integral,
    output logic [STAT_W-1:0]        o_status,
    input  logic                     i_cfg_we,
    input  logic [MODE_W-1:0]        i_cfg_data
);

    logic [MODE_W-1:0] r_mode;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;
    t_entry            front_entry;
    t_entry            back_entry;

    // Hold the mode; the back reads it only when a run closes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_EQ_TRAP;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // Count the run and tag each sample for the back.
    tsi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_x_value     (i_x_value),
        .i_y_value     (i_y_value),
        .i_last_sample (i_last_sample),
        .i_q_full      (q_full),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    // Decouple intake from the multi-cycle back.
    tsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (back_entry)
    );

    // Accumulate and close each run; drive the result transfer.
    tsi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_q_valid  (q_valid),
        .i_entry    (back_entry),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_integral (o_integral),
        .o_status   (o_status)
    );

endmodule
